[rtl/ift_pkg.sv]
// Shared types, sizes and codes for the interrupt fan-out table.
// Used by the interfaces, the controller, the datapath and the top level.
package ift_pkg;

    localparam int NUM_SOURCES      = 8;
    localparam int SLOTS_PER_SOURCE = 4;
    localparam int TOTAL_SLOTS      = NUM_SOURCES * SLOTS_PER_SOURCE;

    localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SLOT_W = (SLOTS_PER_SOURCE > 1) ? $clog2(SLOTS_PER_SOURCE) : 1;
    localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
    localparam int HCNT_W = $clog2(SLOTS_PER_SOURCE + 1);
    localparam int SCNT_W = $clog2(NUM_SOURCES + 1);

    localparam logic [2:0] OP_ADD_SOURCE  = 3'd0;
    localparam logic [2:0] OP_DEL_SOURCE  = 3'd1;
    localparam logic [2:0] OP_ADD_HANDLER = 3'd2;
    localparam logic [2:0] OP_DEL_HANDLER = 3'd3;
    localparam logic [2:0] OP_DISPATCH    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_PARAM = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  irq;
        logic [7:0]  handler_id;
        logic [7:0]  callback_tag;
        logic [15:0] context_req;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  handler_count;
        logic [3:0]  sources_used;
        logic        notify;
        logic [7:0]  out_handler;
        logic [7:0]  out_callback;
        logic [15:0] out_context;
        logic        last;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  handler;
        logic [7:0]  callback;
        logic [15:0] ctx;
    } t_slot;

    typedef struct packed {
        logic capture;
        logic exec;
        logic cmp;
        logic slot_inc;
        logic upd;
        logic load_resp;
        logic load_notify;
        logic load_sum;
    } t_cmd;

    typedef struct packed {
        logic       in_valid;
        logic [2:0] op;
        logic       hid_zero;
        logic       found;
        logic       last_slot;
        logic       cur_active;
        logic       hit_now;
        logic       out_free;
    } t_stat;

endpackage

[rtl/ift_req_if.sv]
// Request channel: valid, ready and one table operation.
// Depends on ift_pkg.
interface ift_req_if import ift_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ift_rsp_if.sv]
// Response channel: valid, ready and one result item.
// Depends on ift_pkg.
interface ift_rsp_if import ift_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/ift_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ift_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/ift_ctrl.sv]
// Sequencer for the fan-out table: steps each operation through the datapath.
// Depends on ift_pkg; drives t_cmd, reads t_stat.
module ift_ctrl import ift_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_RESP = 4'd5;
    localparam logic [3:0] S_DRD  = 4'd6;
    localparam logic [3:0] S_DOUT = 4'd7;
    localparam logic [3:0] S_DSUM = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_stat.in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.op inside {OP_ADD_HANDLER, OP_DEL_HANDLER}) begin
                    n_state = (!i_stat.hid_zero && i_stat.found) ? S_RD : S_RESP;
                end else if (i_stat.op == OP_DISPATCH) begin
                    n_state = i_stat.found ? S_DRD : S_DSUM;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_stat.hit_now || i_stat.last_slot) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_resp = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DRD: begin
                if (i_stat.cur_active) begin
                    n_state = S_DOUT;
                end else if (i_stat.last_slot) begin
                    n_state = S_DSUM;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                end
            end
            S_DOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_notify = 1'b1;
                    if (i_stat.last_slot) begin
                        n_state = S_DSUM;
                    end else begin
                        o_cmd.slot_inc = 1'b1;
                        n_state        = S_DRD;
                    end
                end
            end
            S_DSUM: begin
                if (i_stat.out_free) begin
                    o_cmd.load_sum = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

[rtl/ift_dp.sv]
// Datapath: source table, slot valid bits, slot RAM and result register.
// Depends on ift_pkg and ift_ram; takes t_cmd, reports t_stat.
module ift_dp import ift_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    input  logic  i_in_valid,
    input  t_req  i_req,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    output t_rsp  o_out
);
    t_req                     r_req;
    logic [NUM_SOURCES-1:0]   r_src_valid;
    logic [7:0]               r_src_irq [NUM_SOURCES];
    logic [HCNT_W-1:0]        r_src_cnt [NUM_SOURCES];
    logic [TOTAL_SLOTS-1:0]   r_active;
    logic [SCNT_W-1:0]        r_in_use;
    logic [SRC_W-1:0]         r_src;
    logic [SLOT_W-1:0]        r_slot;
    logic                     r_hit_valid;
    logic [SLOT_W-1:0]        r_hit_slot;
    logic [1:0]               r_status;
    logic [HCNT_W-1:0]        r_ncount;
    logic                     r_out_valid;
    t_rsp                     r_out;

    logic [NUM_SOURCES-1:0]   n_src_valid;
    logic [7:0]               n_src_irq [NUM_SOURCES];
    logic [HCNT_W-1:0]        n_src_cnt [NUM_SOURCES];
    logic [TOTAL_SLOTS-1:0]   n_active;
    logic [SCNT_W-1:0]        n_in_use;
    logic [1:0]               n_status;

    logic                     lk_found;
    logic [SRC_W-1:0]         lk_idx;
    logic                     fr_found;
    logic [SRC_W-1:0]         fr_idx;
    logic                     row_free_found;
    logic [SLOT_W-1:0]        row_free_slot;
    logic [ADDR_W-1:0]        row_base;
    logic [ADDR_W-1:0]        raddr;
    logic [ADDR_W-1:0]        waddr;
    logic                     we;
    t_slot                    wdata;
    t_slot                    rdata;
    logic [$bits(t_slot)-1:0] rdata_raw;
    logic                     cur_active;
    logic                     hit_now;
    logic                     out_free;
    logic                     is_handler_op;

    assign row_base      = ADDR_W'(r_src) * ADDR_W'(SLOTS_PER_SOURCE);
    assign raddr         = row_base + ADDR_W'(r_slot);
    assign cur_active    = r_active[raddr];
    assign rdata         = t_slot'(rdata_raw);
    assign hit_now       = cur_active && (rdata.handler == r_req.handler_id);
    assign out_free      = !r_out_valid || i_out_ready;
    assign is_handler_op = (r_req.op == OP_ADD_HANDLER);

    always_comb begin
        lk_found = 1'b0;
        lk_idx   = '0;
        fr_found = 1'b0;
        fr_idx   = '0;
        for (int i = 0; i < NUM_SOURCES; i++) begin
            if (r_src_valid[i] && (r_src_irq[i] == r_req.irq) && !lk_found) begin
                lk_found = 1'b1;
                lk_idx   = SRC_W'(i);
            end
            if (!r_src_valid[i] && !fr_found) begin
                fr_found = 1'b1;
                fr_idx   = SRC_W'(i);
            end
        end
    end

    always_comb begin
        row_free_found = 1'b0;
        row_free_slot  = '0;
        for (int s = 0; s < SLOTS_PER_SOURCE; s++) begin
            if (!r_active[row_base + ADDR_W'(s)] && !row_free_found) begin
                row_free_found = 1'b1;
                row_free_slot  = SLOT_W'(s);
            end
        end
    end

    assign we    = i_cmd.upd && is_handler_op && (r_hit_valid || row_free_found);
    assign waddr = row_base + ADDR_W'(r_hit_valid ? r_hit_slot : row_free_slot);
    assign wdata = '{handler: r_req.handler_id, callback: r_req.callback_tag,
                     ctx: r_req.context_req};

    ift_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TOTAL_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    always_comb begin
        logic [ADDR_W-1:0] lk_base;
        logic [ADDR_W-1:0] fr_base;
        lk_base     = ADDR_W'(lk_idx) * ADDR_W'(SLOTS_PER_SOURCE);
        fr_base     = ADDR_W'(fr_idx) * ADDR_W'(SLOTS_PER_SOURCE);
        n_src_valid = r_src_valid;
        n_src_irq   = r_src_irq;
        n_src_cnt   = r_src_cnt;
        n_active    = r_active;
        n_in_use    = r_in_use;
        n_status    = r_status;
        if (i_cmd.exec) begin
            n_status = ST_OK;
            case (r_req.op)
                OP_ADD_SOURCE: begin
                    if (!lk_found) begin
                        if (fr_found) begin
                            n_src_valid[fr_idx] = 1'b1;
                            n_src_irq[fr_idx]   = r_req.irq;
                            n_src_cnt[fr_idx]   = '0;
                            for (int s = 0; s < SLOTS_PER_SOURCE; s++) begin
                                n_active[fr_base + ADDR_W'(s)] = 1'b0;
                            end
                            n_in_use = r_in_use + SCNT_W'(1);
                        end else begin
                            n_status = ST_NO_SLOT;
                        end
                    end
                end
                OP_DEL_SOURCE: begin
                    if (lk_found) begin
                        n_src_valid[lk_idx] = 1'b0;
                        n_src_irq[lk_idx]   = '0;
                        n_src_cnt[lk_idx]   = '0;
                        for (int s = 0; s < SLOTS_PER_SOURCE; s++) begin
                            n_active[lk_base + ADDR_W'(s)] = 1'b0;
                        end
                        n_in_use = r_in_use - SCNT_W'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                OP_ADD_HANDLER, OP_DEL_HANDLER: begin
                    if (r_req.handler_id == 8'd0) begin
                        n_status = ST_BAD_PARAM;
                    end else if (!lk_found) begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                OP_DISPATCH: begin
                    n_status = ST_OK;
                end
                default: begin
                    n_status = ST_BAD_PARAM;
                end
            endcase
        end
        if (i_cmd.upd) begin
            if (is_handler_op) begin
                if (!r_hit_valid) begin
                    if (row_free_found) begin
                        n_active[waddr]  = 1'b1;
                        n_src_cnt[r_src] = r_src_cnt[r_src] + HCNT_W'(1);
                    end else begin
                        n_status = ST_NO_SLOT;
                    end
                end
            end else begin
                if (r_hit_valid) begin
                    n_active[waddr]  = 1'b0;
                    n_src_cnt[r_src] = r_src_cnt[r_src] - HCNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_valid <= '0;
            r_src_irq   <= '{default: '0};
            r_src_cnt   <= '{default: '0};
            r_active    <= '0;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_src_valid <= n_src_valid;
            r_src_irq   <= n_src_irq;
            r_src_cnt   <= n_src_cnt;
            r_active    <= n_active;
            r_in_use    <= n_in_use;
            if (i_cmd.load_resp || i_cmd.load_notify || i_cmd.load_sum) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_src       <= lk_idx;
            r_slot      <= '0;
            r_hit_valid <= 1'b0;
            r_hit_slot  <= '0;
            r_ncount    <= '0;
        end
        if (i_cmd.slot_inc) begin
            r_slot <= r_slot + SLOT_W'(1);
        end
        if (i_cmd.cmp && hit_now && !r_hit_valid) begin
            r_hit_valid <= 1'b1;
            r_hit_slot  <= r_slot;
        end
        if (i_cmd.load_notify) begin
            r_ncount <= r_ncount + HCNT_W'(1);
        end
        if (i_cmd.load_resp) begin
            r_out <= '{status: r_status,
                       handler_count: lk_found ? 3'(r_src_cnt[lk_idx]) : 3'd0,
                       sources_used: 4'(r_in_use), notify: 1'b0,
                       out_handler: 8'd0, out_callback: 8'd0, out_context: 16'd0,
                       last: 1'b1};
        end else if (i_cmd.load_notify) begin
            r_out <= '{status: ST_OK, handler_count: 3'(r_src_cnt[r_src]),
                       sources_used: 4'(r_in_use), notify: 1'b1,
                       out_handler: rdata.handler, out_callback: rdata.callback,
                       out_context: rdata.ctx, last: 1'b0};
        end else if (i_cmd.load_sum) begin
            r_out <= '{status: ST_OK, handler_count: 3'(r_ncount),
                       sources_used: 4'(r_in_use), notify: 1'b0,
                       out_handler: 8'd0, out_callback: 8'd0, out_context: 16'd0,
                       last: 1'b1};
        end
    end

    assign o_stat = '{in_valid: i_in_valid, op: r_req.op,
                      hid_zero: (r_req.handler_id == 8'd0), found: lk_found,
                      last_slot: (r_slot == SLOT_W'(SLOTS_PER_SOURCE - 1)),
                      cur_active: cur_active, hit_now: hit_now, out_free: out_free};
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

[rtl/interrupt_fanout_table_core.sv]
// Top level of the interrupt fan-out table: controller, datapath and checks.
// Depends on ift_pkg, ift_req_if, ift_rsp_if, ift_ctrl and ift_dp.
//
// Use: present one table operation on i_req (valid/ready). A transfer takes
// place when valid and ready are both high; ready is high only while the
// block is idle, so one operation is in flight at a time.
// Each operation yields results on o_rsp: one result for source and handler
// operations, and for dispatch one result per active handler in slot order
// followed by a summary carrying the notified count (last marks the final one).
// Source operations and unknown-irq cases go straight to the result. Handler
// operations read and compare one slot at a time until a match or the last slot,
// then update; dispatch reads each slot in turn and offers a result per active
// handler. The slot RAM has a single read port, so slots are visited in turn.
// The next operation is taken in the cycle the final result is first offered, so
// no operation starts before the block is through with the previous one.
// Reset clears the source table and all slot valid bits at once; the slot RAM
// itself is never cleared and its data is used only for active slots.
// When the receiver stalls, the result register holds and the sequencer waits
// before loading the next result; no operation is taken until the last is loaded.
module interrupt_fanout_table_core import ift_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    ift_req_if.sink  i_req,
    ift_rsp_if.source o_rsp
);
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    ift_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    ift_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_valid  (i_req.valid),
        .i_req       (i_req.data),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_out       (o_rsp.data)
    );

    assign i_req.ready = in_ready;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while an operation is in flight");

    a_notify_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.notify) |-> !o_rsp.data.last)
        else $error("notify result marked last");

    a_notify_handler: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.notify) |-> (o_rsp.data.out_handler != 8'd0))
        else $error("null handler notified");
endmodule
